@@ sv/avc_l2sc_pkg.sv @@
`timescale 1ns / 1ps

package avc_l2sc_pkg;

    // parser phases
    typedef enum logic [3:0] {
        PH_CFG_HDR   = 4'd0,
        PH_SPS_COUNT = 4'd1,
        PH_SPS_LEN   = 4'd2,
        PH_SPS_DATA  = 4'd3,
        PH_PPS_COUNT = 4'd4,
        PH_PPS_LEN   = 4'd5,
        PH_PPS_DATA  = 4'd6,
        PH_CFG_DONE  = 4'd7,
        PH_TAG_HDR   = 4'd8,
        PH_NAL_LEN   = 4'd9,
        PH_NAL_DATA  = 4'd10
    } t_phase;

    // what one input beat produces
    typedef enum logic [1:0] {
        RES_NONE  = 2'd0,
        RES_BYTE  = 2'd1,
        RES_START = 2'd2
    } t_res_kind;

    typedef struct packed {
        t_res_kind  kind;
        logic [7:0] data;
    } t_parse_res;

    localparam logic [3:0] CFG_SKIP_LAST = 4'd9;  // ten header bytes of the record
    localparam logic [3:0] TAG_SKIP_LAST = 4'd4;  // five header bytes of a tag
    localparam logic [3:0] SET_LEN_LAST  = 4'd1;  // two-byte parameter set length
    localparam logic [3:0] NAL_LEN_LAST  = 4'd3;  // four-byte nal length

    localparam logic [7:0] SC_BYTES [4] = '{8'h00, 8'h00, 8'h00, 8'h01};
    localparam logic [1:0] SC_LAST_IDX  = 2'd3;

endpackage

@@ sv/avc_l2sc_parse.sv @@
`timescale 1ns / 1ps

module avc_l2sc_parse (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic [7:0]              i_byte,
    input  logic                    i_last,
    output avc_l2sc_pkg::t_parse_res o_res
);

    avc_l2sc_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_pos, n_pos;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_payload, n_payload;
    logic [4:0]  r_sets, n_sets;

    logic                 w_pps;
    avc_l2sc_pkg::t_phase w_len_ph;
    avc_l2sc_pkg::t_phase w_data_ph;
    avc_l2sc_pkg::t_phase w_after_ph;
    logic [31:0]          w_set_len;
    logic [31:0]          w_nal_len;

    // sps and pps lists share the same handling
    assign w_pps = (r_phase == avc_l2sc_pkg::PH_PPS_COUNT) ||
                   (r_phase == avc_l2sc_pkg::PH_PPS_LEN) ||
                   (r_phase == avc_l2sc_pkg::PH_PPS_DATA);
    assign w_len_ph   = w_pps ? avc_l2sc_pkg::PH_PPS_LEN  : avc_l2sc_pkg::PH_SPS_LEN;
    assign w_data_ph  = w_pps ? avc_l2sc_pkg::PH_PPS_DATA : avc_l2sc_pkg::PH_SPS_DATA;
    assign w_after_ph = w_pps ? avc_l2sc_pkg::PH_CFG_DONE : avc_l2sc_pkg::PH_PPS_COUNT;

    assign w_set_len = {16'h0000, r_acc[7:0], i_byte};
    assign w_nal_len = {r_acc[23:0], i_byte};

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_acc     = r_acc;
        n_payload = r_payload;
        n_sets    = r_sets;
        unique case (r_phase) inside
            avc_l2sc_pkg::PH_CFG_HDR: begin
                if (r_pos == avc_l2sc_pkg::CFG_SKIP_LAST) begin
                    n_pos   = 4'd0;
                    n_phase = avc_l2sc_pkg::PH_SPS_COUNT;
                end else begin
                    n_pos = r_pos + 4'd1;
                end
            end
            avc_l2sc_pkg::PH_SPS_COUNT, avc_l2sc_pkg::PH_PPS_COUNT: begin
                n_sets  = i_byte[4:0];
                n_pos   = 4'd0;
                n_acc   = '0;
                n_phase = (i_byte[4:0] == 5'd0) ? w_after_ph : w_len_ph;
            end
            avc_l2sc_pkg::PH_SPS_LEN, avc_l2sc_pkg::PH_PPS_LEN: begin
                if (r_pos == avc_l2sc_pkg::SET_LEN_LAST) begin
                    n_payload = w_set_len;
                    n_pos     = 4'd0;
                    n_acc     = '0;
                    if (w_set_len == 32'd0) begin
                        n_sets  = r_sets - 5'd1;
                        n_phase = (r_sets == 5'd1) ? w_after_ph : w_len_ph;
                    end else begin
                        n_phase = w_data_ph;
                    end
                end else begin
                    n_acc = w_set_len;
                    n_pos = r_pos + 4'd1;
                end
            end
            avc_l2sc_pkg::PH_SPS_DATA, avc_l2sc_pkg::PH_PPS_DATA: begin
                n_payload = r_payload - 32'd1;
                if (r_payload == 32'd1) begin
                    n_sets  = r_sets - 5'd1;
                    n_phase = (r_sets == 5'd1) ? w_after_ph : w_len_ph;
                end
            end
            avc_l2sc_pkg::PH_CFG_DONE: begin
                n_phase = r_phase;  // record trailer ignored
            end
            avc_l2sc_pkg::PH_TAG_HDR: begin
                if (r_pos == avc_l2sc_pkg::TAG_SKIP_LAST) begin
                    n_pos   = 4'd0;
                    n_acc   = '0;
                    n_phase = avc_l2sc_pkg::PH_NAL_LEN;
                end else begin
                    n_pos = r_pos + 4'd1;
                end
            end
            avc_l2sc_pkg::PH_NAL_LEN: begin
                if (r_pos == avc_l2sc_pkg::NAL_LEN_LAST) begin
                    n_payload = w_nal_len;
                    n_pos     = 4'd0;
                    n_acc     = '0;
                    n_phase   = (w_nal_len == 32'd0) ? avc_l2sc_pkg::PH_NAL_LEN
                                                     : avc_l2sc_pkg::PH_NAL_DATA;
                end else begin
                    n_acc = w_nal_len;
                    n_pos = r_pos + 4'd1;
                end
            end
            avc_l2sc_pkg::PH_NAL_DATA: begin
                n_payload = r_payload - 32'd1;
                if (r_payload == 32'd1) begin
                    n_pos   = 4'd0;
                    n_acc   = '0;
                    n_phase = avc_l2sc_pkg::PH_NAL_LEN;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        // end of tag overrides whatever phase we were in
        if (i_last) begin
            n_phase   = avc_l2sc_pkg::PH_TAG_HDR;
            n_pos     = 4'd0;
            n_acc     = '0;
            n_payload = '0;
            n_sets    = 5'd0;
        end
    end

    // result of the current beat
    always_comb begin
        o_res.data = i_byte;
        unique case (r_phase) inside
            avc_l2sc_pkg::PH_SPS_LEN, avc_l2sc_pkg::PH_PPS_LEN: begin
                o_res.kind = (r_pos == avc_l2sc_pkg::SET_LEN_LAST) ?
                             avc_l2sc_pkg::RES_START : avc_l2sc_pkg::RES_NONE;
            end
            avc_l2sc_pkg::PH_NAL_LEN: begin
                o_res.kind = (r_pos == avc_l2sc_pkg::NAL_LEN_LAST) ?
                             avc_l2sc_pkg::RES_START : avc_l2sc_pkg::RES_NONE;
            end
            avc_l2sc_pkg::PH_SPS_DATA, avc_l2sc_pkg::PH_PPS_DATA,
            avc_l2sc_pkg::PH_NAL_DATA: begin
                o_res.kind = avc_l2sc_pkg::RES_BYTE;
            end
            default: begin
                o_res.kind = avc_l2sc_pkg::RES_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= avc_l2sc_pkg::PH_CFG_HDR;
            r_pos     <= 4'd0;
            r_acc     <= '0;
            r_payload <= '0;
            r_sets    <= 5'd0;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_acc     <= n_acc;
            r_payload <= n_payload;
            r_sets    <= n_sets;
        end
    end

endmodule

@@ sv/avc_length_prefix_to_start_code.sv @@
`timescale 1ns / 1ps

// channel   dir  tdata           tuser        tlast
// s_axis    in   body_byte[7:0]  -            body_last
// m_axis    out  out_byte[7:0]   unit_start   run_last
//
// one body byte is taken per cycle while m_axis is free and no start code is
// pending; a payload byte appears on m_axis in the cycle after its beat is taken
// the last byte of a length prefix produces a four-byte start code, and the
// slave side is held off while the output register plays out its remaining
// bytes; header, count and other length bytes produce nothing
// synchronous active-low reset returns the parser to the record header skip
// a stall on m_axis holds the output register and backs up into s_axis

module avc_length_prefix_to_start_code (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] body_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tuser,   // [0] unit_start
    output logic       o_m_axis_tlast
);

    avc_l2sc_pkg::t_parse_res w_res;

    logic       w_free;     // output register can be loaded this cycle
    logic       w_in_acc;
    logic [1:0] w_sc_idx;

    // output register and start code sequencer
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte,  n_out_byte;
    logic       r_out_user,  n_out_user;
    logic       r_out_last,  n_out_last;
    logic [1:0] r_sc_left,   n_sc_left;   // start code bytes still to load

    assign w_free          = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_free && (r_sc_left == 2'd0);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    // three left -> byte 1, two -> byte 2, one -> byte 3
    assign w_sc_idx = 2'd0 - r_sc_left;

    avc_l2sc_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_in_acc),
        .i_byte  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_res   (w_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_user  = r_out_user;
        n_out_last  = r_out_last;
        n_sc_left   = r_sc_left;
        if (w_in_acc) begin
            case (w_res.kind)
                avc_l2sc_pkg::RES_BYTE: begin
                    n_out_valid = 1'b1;
                    n_out_byte  = w_res.data;
                    n_out_user  = 1'b0;
                    n_out_last  = 1'b1;
                end
                avc_l2sc_pkg::RES_START: begin
                    // first start code byte now, the rest follow
                    n_out_valid = 1'b1;
                    n_out_byte  = avc_l2sc_pkg::SC_BYTES[0];
                    n_out_user  = 1'b1;
                    n_out_last  = 1'b0;
                    n_sc_left   = 2'd3;
                end
                default: begin
                    n_out_valid = 1'b0;
                end
            endcase
        end else if (r_sc_left != 2'd0 && w_free) begin
            n_out_valid = 1'b1;
            n_out_byte  = avc_l2sc_pkg::SC_BYTES[w_sc_idx];
            n_out_user  = 1'b0;
            n_out_last  = (w_sc_idx == avc_l2sc_pkg::SC_LAST_IDX);
            n_sc_left   = r_sc_left - 2'd1;
        end else if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sc_left   <= 2'd0;
        end else begin
            r_out_valid <= n_out_valid;
            r_sc_left   <= n_sc_left;
        end
    end

    // payload of the output register, no reset needed
    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;

`ifndef ASSERT_OFF
    // a start code beat puts 00 with unit_start on the output next cycle
    a_sc_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_res.kind == avc_l2sc_pkg::RES_START) |=>
        (o_m_axis_tvalid && o_m_axis_tuser && o_m_axis_tdata == 8'h00 &&
         !o_m_axis_tlast))
        else $error("start code did not open with 00 and unit_start");

    // while start code bytes are pending the output holds a non-final beat
    a_sc_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sc_left != 2'd0) |-> (o_m_axis_tvalid && !o_m_axis_tlast))
        else $error("start code sequence broken");

    // the unit start byte is never the last of its run
    a_user_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> !o_m_axis_tlast)
        else $error("unit_start on a run's last beat");

    // run_last with value 01 closes a start code
    a_sc_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_sc_left) == 2'd1 && r_sc_left == 2'd0 && $past(w_free)) |->
        (o_m_axis_tvalid && o_m_axis_tlast && o_m_axis_tdata == 8'h01))
        else $error("start code did not close with 01");
`endif

endmodule
